/* src/ppr_pkg.sv */
// ----------------------------------------------------------------------------
// ppr_pkg
// Shared types and codes for the pipe pool: operation codes, result status
// codes and the result record passed from control to the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

package ppr_pkg;

    typedef enum logic [2:0] {
        MODE_ALLOC    = 3'd0,
        MODE_WRITE    = 3'd1,
        MODE_READ     = 3'd2,
        MODE_CLOSE_RD = 3'd3,
        MODE_CLOSE_WR = 3'd4
    } t_mode;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_NOFREE = 3'd1,
        ST_FULL   = 3'd2,
        ST_EMPTY  = 3'd3,
        ST_EOD    = 3'd4,
        ST_BROKEN = 3'd5,
        ST_BAD    = 3'd6
    } t_status;

    typedef struct packed {
        t_status    status;
        logic [1:0] number;
        logic [4:0] fill;
        logic       rd_hit;
    } t_result;

endpackage

`default_nettype wire

/* src/ppr_store.sv */
// ----------------------------------------------------------------------------
// ppr_store
// Byte storage for all pipes: one write port, one read port with registered
// read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ppr_store #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [7:0]        i_wr_data,
    input  wire logic              i_rd_en,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic      [7:0]        o_rd_data
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_q <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_q;

endmodule

`default_nettype wire

/* src/ppr_ctrl.sv */
// ----------------------------------------------------------------------------
// ppr_ctrl
// Per-pipe bookkeeping (head, tail, fill, in-use and end flags), the
// decision for one item, and the storage addresses it needs.
// ----------------------------------------------------------------------------
`default_nettype none

module ppr_ctrl #(
    parameter int PIPE_DEPTH = 16,
    parameter int PIPE_COUNT = 4,
    parameter int ADDR_W     = 6
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_go,
    input  wire logic [2:0]           i_mode,
    input  wire logic [1:0]           i_pipe_id,
    output ppr_pkg::t_result          o_res,
    output logic                      o_wr_en,
    output logic      [ADDR_W-1:0]    o_wr_addr,
    output logic                      o_rd_en,
    output logic      [ADDR_W-1:0]    o_rd_addr
);

    import ppr_pkg::*;

    localparam int IDX_W  = $clog2(PIPE_DEPTH);
    localparam int FILL_W = $clog2(PIPE_DEPTH + 1);
    localparam int PID_W  = (PIPE_COUNT > 1) ? $clog2(PIPE_COUNT) : 1;

    logic [IDX_W-1:0]  r_head   [PIPE_COUNT];
    logic [IDX_W-1:0]  r_tail   [PIPE_COUNT];
    logic [FILL_W-1:0] r_fill   [PIPE_COUNT];
    logic              r_in_use [PIPE_COUNT];
    logic              r_rd_open[PIPE_COUNT];
    logic              r_wr_open[PIPE_COUNT];

    logic              s_in_range;
    logic [PID_W-1:0]  s_p;
    logic              s_live;
    logic              s_rd_open;
    logic              s_wr_open;
    logic [IDX_W-1:0]  s_head;
    logic [IDX_W-1:0]  s_tail;
    logic [FILL_W-1:0] s_fill;
    logic [FILL_W-1:0] s_fill_new;
    logic              s_found;
    logic [PID_W-1:0]  s_free_idx;
    logic              s_do_alloc;
    logic              s_do_write;
    logic              s_do_read;
    logic              s_do_free;
    logic              s_clr_rd;
    logic              s_clr_wr;
    logic [ADDR_W-1:0] s_base;
    t_status           s_status;
    logic [1:0]        s_number;

    assign s_in_range = (32'(i_pipe_id) < PIPE_COUNT);
    assign s_p        = PID_W'(i_pipe_id);
    assign s_live     = s_in_range ? r_in_use[s_p]  : 1'b0;
    assign s_rd_open  = s_in_range ? r_rd_open[s_p] : 1'b0;
    assign s_wr_open  = s_in_range ? r_wr_open[s_p] : 1'b0;
    assign s_head     = s_in_range ? r_head[s_p]    : '0;
    assign s_tail     = s_in_range ? r_tail[s_p]    : '0;
    assign s_fill     = s_in_range ? r_fill[s_p]    : '0;

    // lowest free pipe
    always_comb begin
        s_found    = 1'b0;
        s_free_idx = '0;
        for (int i = PIPE_COUNT - 1; i >= 0; i--) begin
            if (!r_in_use[i]) begin
                s_found    = 1'b1;
                s_free_idx = PID_W'(i);
            end
        end
    end

    always_comb begin
        s_status   = ST_BAD;
        s_number   = i_pipe_id;
        s_do_alloc = 1'b0;
        s_do_write = 1'b0;
        s_do_read  = 1'b0;
        s_do_free  = 1'b0;
        s_clr_rd   = 1'b0;
        s_clr_wr   = 1'b0;
        unique case (t_mode'(i_mode))
            MODE_ALLOC: begin
                s_number = '0;
                if (s_found) begin
                    s_status   = ST_OK;
                    s_number   = 2'(s_free_idx);
                    s_do_alloc = 1'b1;
                end else begin
                    s_status = ST_NOFREE;
                end
            end
            MODE_WRITE: begin
                if (s_live && s_wr_open) begin
                    priority if (!s_rd_open) begin
                        s_status = ST_BROKEN;
                    end else if (s_fill >= FILL_W'(PIPE_DEPTH)) begin
                        s_status = ST_FULL;
                    end else begin
                        s_status   = ST_OK;
                        s_do_write = 1'b1;
                    end
                end
            end
            MODE_READ: begin
                if (s_live && s_rd_open) begin
                    priority if (s_fill != '0) begin
                        s_status  = ST_OK;
                        s_do_read = 1'b1;
                    end else if (s_wr_open) begin
                        s_status = ST_EMPTY;
                    end else begin
                        s_status  = ST_EOD;
                        s_do_free = 1'b1;
                    end
                end
            end
            MODE_CLOSE_RD: begin
                if (s_live && s_rd_open) begin
                    s_status  = ST_OK;
                    s_clr_rd  = s_wr_open;
                    s_do_free = !s_wr_open;
                end
            end
            MODE_CLOSE_WR: begin
                if (s_live && s_wr_open) begin
                    s_status  = ST_OK;
                    s_clr_wr  = s_rd_open;
                    s_do_free = !s_rd_open;
                end
            end
            default: begin
                s_status = ST_BAD;
            end
        endcase
    end

    always_comb begin
        priority if (s_do_alloc || s_do_free || !s_in_range
                     || t_mode'(i_mode) == MODE_ALLOC) begin
            s_fill_new = '0;
        end else if (s_do_write) begin
            s_fill_new = s_fill + FILL_W'(1);
        end else if (s_do_read) begin
            s_fill_new = s_fill - FILL_W'(1);
        end else begin
            s_fill_new = s_fill;
        end
    end

    assign o_res.status = s_status;
    assign o_res.number = s_number;
    assign o_res.fill   = 5'(s_fill_new);
    assign o_res.rd_hit = s_do_read;

    assign s_base    = ADDR_W'(s_p) * ADDR_W'(PIPE_DEPTH);
    assign o_wr_addr = s_base + ADDR_W'(s_head);
    assign o_rd_addr = s_base + ADDR_W'(s_tail);
    assign o_wr_en   = i_go && s_do_write;
    assign o_rd_en   = i_go && s_do_read;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PIPE_COUNT; i++) begin
                r_head[i]    <= '0;
                r_tail[i]    <= '0;
                r_fill[i]    <= '0;
                r_in_use[i]  <= 1'b0;
                r_rd_open[i] <= 1'b0;
                r_wr_open[i] <= 1'b0;
            end
        end else if (i_go) begin
            if (s_do_alloc) begin
                r_head[s_free_idx]    <= '0;
                r_tail[s_free_idx]    <= '0;
                r_fill[s_free_idx]    <= '0;
                r_in_use[s_free_idx]  <= 1'b1;
                r_rd_open[s_free_idx] <= 1'b1;
                r_wr_open[s_free_idx] <= 1'b1;
            end
            if (s_do_write) begin
                r_head[s_p] <= (s_head == IDX_W'(PIPE_DEPTH - 1)) ? '0 : s_head + IDX_W'(1);
                r_fill[s_p] <= s_fill_new;
            end
            if (s_do_read) begin
                r_tail[s_p] <= (s_tail == IDX_W'(PIPE_DEPTH - 1)) ? '0 : s_tail + IDX_W'(1);
                r_fill[s_p] <= s_fill_new;
            end
            if (s_clr_rd) begin
                r_rd_open[s_p] <= 1'b0;
            end
            if (s_clr_wr) begin
                r_wr_open[s_p] <= 1'b0;
            end
            if (s_do_free) begin
                r_head[s_p]    <= '0;
                r_tail[s_p]    <= '0;
                r_fill[s_p]    <= '0;
                r_in_use[s_p]  <= 1'b0;
                r_rd_open[s_p] <= 1'b0;
                r_wr_open[s_p] <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

/* src/pipe_pool_ring_fifo.sv */
// ----------------------------------------------------------------------------
// pipe_pool_ring_fifo
// Pool of byte pipes, each a ring buffer with end flags. One operation per
// item (allocate, write, read, close either end), one result item back.
//
//   channel | direction | handshake                 | payload
//   in      | to block  | i_in_valid / o_in_stall   | i_mode, i_pipe_id, i_write_byte
//   out     | from it   | o_out_valid / i_out_stall | o_status, o_pipe_number,
//           |           |                           | o_read_byte, o_fill_level
//
// An accepted item passes the input register, then the decision and storage
// access, then the result register with the registered read. One item per
// cycle sustained while the output is not stalled; the result register frees
// the input side. A stall on the output holds both registers; synchronous
// reset clears the pipe state and both valids, the byte storage is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module pipe_pool_ring_fifo #(
    parameter int PIPE_DEPTH = 16,
    parameter int PIPE_COUNT = 4
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [2:0] i_mode,
    input  wire logic [1:0] i_pipe_id,
    input  wire logic [7:0] i_write_byte,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic      [2:0] o_status,
    output logic      [1:0] o_pipe_number,
    output logic      [7:0] o_read_byte,
    output logic      [4:0] o_fill_level
);

    import ppr_pkg::*;

    localparam int STORE_D = PIPE_COUNT * PIPE_DEPTH;
    localparam int ADDR_W  = $clog2(STORE_D);

    logic              r_in_valid;
    logic [2:0]        r_mode;
    logic [1:0]        r_pipe_id;
    logic [7:0]        r_wbyte;
    logic              r_out_valid;
    t_result           r_res;
    logic              s_go;
    t_result           s_res;
    logic              s_wr_en;
    logic [ADDR_W-1:0] s_wr_addr;
    logic              s_rd_en;
    logic [ADDR_W-1:0] s_rd_addr;
    logic [7:0]        s_rd_data;

    assign s_go       = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !s_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_mode    <= i_mode;
            r_pipe_id <= i_pipe_id;
            r_wbyte   <= i_write_byte;
        end
    end

    ppr_ctrl #(
        .PIPE_DEPTH (PIPE_DEPTH),
        .PIPE_COUNT (PIPE_COUNT),
        .ADDR_W     (ADDR_W)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_go      (s_go),
        .i_mode    (r_mode),
        .i_pipe_id (r_pipe_id),
        .o_res     (s_res),
        .o_wr_en   (s_wr_en),
        .o_wr_addr (s_wr_addr),
        .o_rd_en   (s_rd_en),
        .o_rd_addr (s_rd_addr)
    );

    ppr_store #(
        .DEPTH  (STORE_D),
        .ADDR_W (ADDR_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (s_wr_en),
        .i_wr_addr (s_wr_addr),
        .i_wr_data (r_wbyte),
        .i_rd_en   (s_rd_en),
        .i_rd_addr (s_rd_addr),
        .o_rd_data (s_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || !i_out_stall) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_go) begin
            r_res <= s_res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_res.status;
    assign o_pipe_number = r_res.number;
    assign o_fill_level  = r_res.fill;
    assign o_read_byte   = r_res.rd_hit ? s_rd_data : 8'd0;

`ifndef ASSERT_OFF
    a_go_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_go |=> o_out_valid)
        else $error("accepted item produced no result");

    a_held_result_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> (r_out_valid && $stable(r_res)))
        else $error("stalled result lost or changed");

    a_byte_only_on_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && r_res.rd_hit) |-> (o_status == ST_OK))
        else $error("read byte on a failed operation");

    a_nofree_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_NOFREE)
            |-> (o_pipe_number == 2'd0 && o_fill_level == 5'd0))
        else $error("no-free result carries a pipe or fill");
`endif

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for pipe_pool_ring_fifo. A tracker keeps its own copy
// of every pipe (ring contents, indices, fill count, in-use and end flags).
// For each accepted operation it predicts the status, pipe number, read byte
// and fill level. Each accepted result is checked in order against that
// prediction. Stimulus starts with a directed pass over the corner cases.
// Random phases follow: fill-heavy and drain-heavy runs around a focus pipe.
// The output side stalls and the input side idles in random bursts.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ppr_pkg::*;

    localparam int DEPTH = 16;
    localparam int COUNT = 4;

    typedef struct {
        t_status    status;
        logic [1:0] number;
        logic [7:0] rbyte;
        logic [4:0] level;
    } t_pipe_reply;

    class pool_tracker;
        logic [7:0]  ring_bytes [COUNT*DEPTH];
        logic [3:0]  head [COUNT];
        logic [3:0]  tail [COUNT];
        logic [4:0]  fill [COUNT];
        bit          busy [COUNT];
        bit          rd_open [COUNT];
        bit          wr_open [COUNT];
        t_pipe_reply replies [$];
        int          mismatches;

        function new();
            for (int p = 0; p < COUNT; p++) begin
                release_pipe(p);
            end
            mismatches = 0;
        endfunction

        function void release_pipe(int p);
            busy[p]    = 0;
            rd_open[p] = 0;
            wr_open[p] = 0;
            head[p]    = 0;
            tail[p]    = 0;
            fill[p]    = 0;
        endfunction

        function void accept_op(logic [2:0] mode, logic [1:0] pid, logic [7:0] wb);
            t_pipe_reply r;
            int          p;
            p        = pid;
            r.status = ST_BAD;
            r.number = pid;
            r.rbyte  = 8'd0;
            r.level  = 5'd0;
            if (mode == MODE_ALLOC) begin
                r.status = ST_NOFREE;
                r.number = 2'd0;
                for (int i = 0; i < COUNT; i++) begin
                    if (!busy[i] && r.status == ST_NOFREE) begin
                        release_pipe(i);
                        busy[i]    = 1;
                        rd_open[i] = 1;
                        wr_open[i] = 1;
                        r.status   = ST_OK;
                        r.number   = 2'(i);
                    end
                end
            end else if (busy[p]) begin
                case (mode)
                    MODE_WRITE: begin
                        if (!wr_open[p]) begin
                            r.status = ST_BAD;
                        end else if (!rd_open[p]) begin
                            r.status = ST_BROKEN;
                        end else if (fill[p] >= DEPTH) begin
                            r.status = ST_FULL;
                        end else begin
                            ring_bytes[p*DEPTH + head[p]] = wb;
                            head[p]  = (head[p] == DEPTH - 1) ? 4'd0 : head[p] + 4'd1;
                            fill[p]  = fill[p] + 5'd1;
                            r.status = ST_OK;
                        end
                    end
                    MODE_READ: begin
                        if (!rd_open[p]) begin
                            r.status = ST_BAD;
                        end else if (fill[p] > 0) begin
                            r.rbyte  = ring_bytes[p*DEPTH + tail[p]];
                            tail[p]  = (tail[p] == DEPTH - 1) ? 4'd0 : tail[p] + 4'd1;
                            fill[p]  = fill[p] - 5'd1;
                            r.status = ST_OK;
                        end else if (wr_open[p]) begin
                            r.status = ST_EMPTY;
                        end else begin
                            release_pipe(p);
                            r.status = ST_EOD;
                        end
                    end
                    MODE_CLOSE_RD: begin
                        if (rd_open[p]) begin
                            rd_open[p] = 0;
                            if (!wr_open[p]) begin
                                release_pipe(p);
                            end
                            r.status = ST_OK;
                        end
                    end
                    MODE_CLOSE_WR: begin
                        if (wr_open[p]) begin
                            wr_open[p] = 0;
                            if (!rd_open[p]) begin
                                release_pipe(p);
                            end
                            r.status = ST_OK;
                        end
                    end
                    default: r.status = ST_BAD;
                endcase
            end
            if (r.status != ST_NOFREE) begin
                r.level = fill[r.number];
            end
            replies.push_back(r);
        endfunction

        function void match_result(logic [2:0] st, logic [1:0] num, logic [7:0] rb,
                                   logic [4:0] lvl);
            t_pipe_reply e;
            if (replies.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result: status %0d pipe %0d byte %0h fill %0d",
                             st, num, rb, lvl);
                end
                return;
            end
            e = replies.pop_front();
            if (st !== e.status || num !== e.number || rb !== e.rbyte || lvl !== e.level) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch: status %0d/%0d pipe %0d/%0d byte %0h/%0h fill %0d/%0d",
                             st, e.status, num, e.number, rb, e.rbyte, lvl, e.level);
                end
            end
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    logic [2:0] i_mode;
    logic [1:0] i_pipe_id;
    logic [7:0] i_write_byte;
    logic       o_out_valid;
    logic       i_out_stall;
    logic [2:0] o_status;
    logic [1:0] o_pipe_number;
    logic [7:0] o_read_byte;
    logic [4:0] o_fill_level;

    pool_tracker tracker;
    bit          calm = 0;

    pipe_pool_ring_fifo DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_mode        (i_mode),
        .i_pipe_id     (i_pipe_id),
        .i_write_byte  (i_write_byte),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_pipe_number (o_pipe_number),
        .o_read_byte   (o_read_byte),
        .o_fill_level  (o_fill_level)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                tracker.match_result(o_status, o_pipe_number, o_read_byte, o_fill_level);
            end
            if (i_in_valid && !o_in_stall) begin
                tracker.accept_op(i_mode, i_pipe_id, i_write_byte);
            end
        end
    end

    initial begin
        i_out_stall <= 1'b0;
        forever begin
            repeat ($urandom_range(1, 40)) @(posedge i_clk);
            if (!calm) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    task automatic send_op(input logic [2:0] m, input logic [1:0] p, input logic [7:0] b);
        i_in_valid   <= 1'b1;
        i_mode       <= m;
        i_pipe_id    <= p;
        i_write_byte <= b;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (tracker.replies.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic run_directed();
        send_op(MODE_ALLOC, 2'd3, 8'h00);
        send_op(MODE_WRITE, 2'd0, 8'h00);
        send_op(MODE_WRITE, 2'd0, 8'hFF);
        send_op(MODE_READ, 2'd0, 8'h00);
        send_op(MODE_READ, 2'd0, 8'h00);
        send_op(MODE_READ, 2'd0, 8'h00);       // empty, writer still open
        send_op(MODE_CLOSE_WR, 2'd0, 8'h00);
        send_op(MODE_WRITE, 2'd0, 8'h11);      // writer end already closed
        send_op(MODE_READ, 2'd0, 8'h00);       // end of data, pipe freed
        send_op(MODE_READ, 2'd0, 8'h00);       // pipe not in use
        repeat (5) send_op(MODE_ALLOC, 2'd0, 8'h00);
        send_op(MODE_CLOSE_RD, 2'd1, 8'h00);
        send_op(MODE_WRITE, 2'd1, 8'hA5);      // broken pipe
        send_op(MODE_CLOSE_RD, 2'd1, 8'h00);
        send_op(MODE_CLOSE_WR, 2'd1, 8'h00);   // both ends closed, freed
        send_op(MODE_CLOSE_WR, 2'd2, 8'h00);
        send_op(MODE_CLOSE_WR, 2'd2, 8'h00);
        send_op(3'd5, 2'd3, 8'hFF);
        send_op(3'd7, 2'd2, 8'h5A);
        send_op(3'd6, 2'd1, 8'h00);
    endtask

    task automatic run_random(input int total);
        bit         fill_phase;
        int         focus;
        int         idle_pct;
        int         r;
        logic [2:0] m;
        logic [2:0] main_op;
        logic [2:0] other_op;
        logic [1:0] p;
        fill_phase = 1;
        focus      = 0;
        idle_pct   = 0;
        for (int n = 0; n < total; n++) begin
            if (n % 60 == 0) begin
                fill_phase = $urandom_range(0, 1);
                focus      = $urandom_range(0, 3);
                idle_pct   = $urandom_range(0, 2) * 25;
            end
            if (n == total - 150) begin
                calm = 1;
            end
            main_op  = fill_phase ? MODE_WRITE : MODE_READ;
            other_op = fill_phase ? MODE_READ : MODE_WRITE;
            r = $urandom_range(0, 99);
            p = ($urandom_range(0, 4) == 0) ? 2'($urandom_range(0, 3)) : 2'(focus);
            if (r < 5) begin
                m = MODE_ALLOC;
            end else if (r < 80) begin
                m = main_op;
            end else if (r < 93) begin
                m = other_op;
            end else if (r < 95) begin
                m = MODE_CLOSE_RD;
            end else if (r < 97) begin
                m = MODE_CLOSE_WR;
            end else begin
                m = 3'($urandom_range(5, 7));
            end
            send_op(m, p, 8'($urandom_range(0, 255)));
            if (!calm && $urandom_range(0, 99) < idle_pct) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end
        end
    endtask

    initial begin
        tracker = new();
        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_mode       <= MODE_ALLOC;
        i_pipe_id    <= 2'd0;
        i_write_byte <= 8'd0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        run_directed();
        wait_drained();
        run_random(1626);
        wait_drained();
        repeat (8) @(posedge i_clk);
        if (tracker.mismatches == 0 && tracker.replies.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("CHECK FAILED");
        $finish;
    end
endmodule

/* files.f */
src/ppr_pkg.sv
src/ppr_store.sv
src/ppr_ctrl.sv
src/pipe_pool_ring_fifo.sv
tb/sv/tb.sv
